// ----- rtl/scpd_pkg.sv -----
package scpd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = $clog2(MAX_PAYLOAD);
    localparam int Q_DEPTH = 2;
    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PREAMBLE = 8'hA5;
    localparam logic [7:0] TYPE_LIMIT_RESET = 8'd5;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_BAD_TYPE = 2'd2,
        ST_BAD_LEN  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_LEN  = 3'd2,
        PH_RECH = 3'd3,
        PH_RECL = 3'd4,
        PH_DATA = 3'd5,
        PH_CHK  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_LOAD = 2'd2,
        B_HOLD = 2'd3
    } back_state_t;

    // one finished packet (or error) handed from front to back
    typedef struct packed {
        status_t           status;
        logic [7:0]        ptype;
        logic [LEN_W-1:0]  length;
        logic [15:0]       record;
    } job_t;

endpackage

// ----- rtl/scpd_ram.sv -----
module scpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/scpd_front.sv -----
module scpd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    input  logic                       q_full,
    input  logic                       back_busy,
    output logic                       push,
    output scpd_pkg::job_t             push_job,
    output logic                       wr_en,
    output logic [scpd_pkg::IDX_W-1:0] wr_addr,
    output logic [7:0]                 wr_data
);

    import scpd_pkg::*;

    logic [7:0]       limit_reg;
    phase_t           phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      rec_reg, rec_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic [7:0]       sum_add;

    // a payload byte may not overwrite the buffer while the back still drains it
    assign in_ready = !q_full && !(phase_reg == PH_DATA && back_busy);
    assign accept   = in_valid && in_ready;
    assign sum_add  = sum_reg + rx_byte;

    assign wr_en   = accept && (phase_reg == PH_DATA);
    assign wr_addr = cnt_reg[IDX_W-1:0];
    assign wr_data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= TYPE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            rec_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            rec_reg   <= rec_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        rec_next   = rec_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        push_job   = '{status: ST_GOOD, ptype: type_reg, length: len_reg, record: rec_reg};
        if (accept)
        begin
            sum_next = sum_add;
            case (phase_reg)
                PH_HUNT:
                begin
                    sum_next = '0;
                    if (rx_byte == PREAMBLE)
                    begin
                        phase_next = PH_TYPE;
                        sum_next   = PREAMBLE;
                    end
                end
                PH_TYPE:
                begin
                    type_next = rx_byte;
                    if (rx_byte < limit_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_job   = '{status: ST_BAD_TYPE, ptype: rx_byte,
                                       length: '0, record: '0};
                        phase_next = PH_HUNT;
                        sum_next   = '0;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte <= 8'(MAX_PAYLOAD))
                    begin
                        len_next = rx_byte[LEN_W-1:0];
                        if (rx_byte != 8'd0)
                        begin
                            phase_next = PH_RECH;
                        end
                        else
                        begin
                            rec_next   = '0;
                            phase_next = PH_CHK;
                        end
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_job   = '{status: ST_BAD_LEN, ptype: '0, length: '0, record: '0};
                        phase_next = PH_HUNT;
                        sum_next   = '0;
                    end
                end
                PH_RECH:
                begin
                    rec_next   = {rx_byte, 8'h00};
                    phase_next = PH_RECL;
                end
                PH_RECL:
                begin
                    rec_next   = {rec_reg[15:8], rx_byte};
                    cnt_next   = '0;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                    if (cnt_reg + LEN_W'(1) >= len_reg)
                    begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    push       = 1'b1;
                    push_job   = '{status: (sum_add == 8'd0) ? ST_GOOD : ST_BAD_SUM,
                                   ptype: type_reg, length: len_reg, record: rec_reg};
                    phase_next = PH_HUNT;
                    sum_next   = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    sum_next   = '0;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !back_busy)
        else $error("payload write while buffer is draining");
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cnt_reg < len_reg))
        else $error("payload write beyond packet length");
    a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_job.status == ST_BAD_LEN) |-> (push_job.ptype == 8'd0))
        else $error("length error carries a type");
`endif

endmodule

// ----- rtl/scpd_queue.sv -----
module scpd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scpd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output scpd_pkg::job_t head
);

    import scpd_pkg::*;

    job_t            slot_reg [Q_DEPTH];
    logic [QP_W-1:0] wp_reg, rp_reg;
    logic [QC_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QC_W'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wp_reg + QP_W'(1);
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rp_reg + QP_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QC_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QC_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue underflow");
`endif

endmodule

// ----- rtl/scpd_back.sv -----
module scpd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  scpd_pkg::job_t             q_head,
    output logic                       pop,
    output logic                       busy,
    output logic                       rd_en,
    output logic [scpd_pkg::IDX_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output scpd_pkg::status_t          o_status,
    output logic [7:0]                 o_type,
    output logic [scpd_pkg::LEN_W-1:0] o_length,
    output logic [15:0]                o_record,
    output logic [7:0]                 o_byte,
    output logic [scpd_pkg::IDX_W-1:0] o_index,
    output logic                       o_last
);

    import scpd_pkg::*;

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       byte_reg, byte_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;
    logic             last_reg, last_next;

    assign busy      = (state_reg != B_IDLE) || !q_empty;
    assign rd_en     = (state_reg == B_READ);
    assign rd_addr   = idx_reg;
    assign out_valid = (state_reg == B_HOLD);
    assign o_status  = job_reg.status;
    assign o_type    = job_reg.ptype;
    assign o_length  = job_reg.length;
    assign o_record  = job_reg.record;
    assign o_byte    = byte_reg;
    assign o_index   = oidx_reg;
    assign o_last    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        oidx_reg <= oidx_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        oidx_next  = oidx_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    job_next = q_head;
                    idx_next = '0;
                    if (q_head.status == ST_GOOD && q_head.length != '0)
                    begin
                        state_next = B_READ;
                    end
                    else
                    begin
                        // errors and empty packets: a single result
                        byte_next  = '0;
                        oidx_next  = '0;
                        last_next  = 1'b1;
                        state_next = B_HOLD;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                byte_next  = rd_data;
                oidx_next  = idx_reg;
                last_next  = ({1'b0, idx_reg} + LEN_W'(1)) == job_reg.length;
                state_next = B_HOLD;
            end
            B_HOLD:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && o_status != ST_GOOD) |-> o_last)
        else $error("error result not marked last");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && o_length != '0 && o_status == ST_GOOD)
            |-> ({1'b0, o_index} < o_length))
        else $error("payload index beyond length");
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && o_status != ST_GOOD) |-> (o_byte == 8'd0 && o_index == '0))
        else $error("error result carries payload");
`endif

endmodule

// ----- rtl/sum_checked_packet_deframer.sv -----
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// config   | cfg_we               | cfg_wdata (type_limit)
// input    | in_valid / in_ready  | rx_byte
// output   | out_valid / out_ready| status, packet_type, payload_length,
//          |                      | record_number, payload_byte, byte_index, last
//
// The parser takes one byte a cycle while in_ready is high; finished packets wait in
// a 2-entry job queue. Single results (errors, empty packets) go from idle straight to
// the beat; payload results pass buffer read, load and beat (registered buffer read).
// in_ready drops while the job queue is full, and on a payload byte while an
// earlier packet still drains from the shared payload buffer.
// Reset clears control state only; the payload buffer needs no clearing pass.
module sum_checked_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  packet_type,
    output logic [scpd_pkg::LEN_W-1:0] payload_length,
    output logic [15:0] record_number,
    output logic [7:0]  payload_byte,
    output logic [scpd_pkg::IDX_W-1:0] byte_index,
    output logic        last
);

    import scpd_pkg::*;

    logic             q_full, q_empty, push, pop, back_busy;
    job_t             push_job, q_head;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [7:0]       wr_data, rd_data;
    status_t          o_status;

    scpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .back_busy (back_busy),
        .push      (push),
        .push_job  (push_job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    scpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    scpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    scpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .busy      (back_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .o_status  (o_status),
        .o_type    (packet_type),
        .o_length  (payload_length),
        .o_record  (record_number),
        .o_byte    (payload_byte),
        .o_index   (byte_index),
        .o_last    (last)
    );

    assign status = o_status;

endmodule

// ----- dv/tb_sum_checked_packet_deframer.sv -----
`timescale 1ns / 100ps

module tb_sum_checked_packet_deframer;
    import scpd_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        status_t          st;
        logic [7:0]       ptype;
        logic [LEN_W-1:0] len;
        logic [15:0]      rec;
        logic [7:0]       pbyte;
        logic [IDX_W-1:0] idx;
        logic             fin;
    } frame_beat_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] packet_type;
    logic [LEN_W-1:0] payload_length;
    logic [15:0] record_number;
    logic [7:0] payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic last;

    logic [7:0] rx_stream[$];
    frame_beat_t expected_beats[$];
    int err_cnt = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic recv_hold = 1'b0;

    // deframer shadow state
    logic [7:0] type_limit = TYPE_LIMIT_RESET;
    phase_t parse_ph = PH_HUNT;
    logic [7:0] run_sum = 8'h00;
    logic [7:0] hold_type = 8'h00;
    logic [LEN_W-1:0] hold_len = '0;
    logic [15:0] hold_rec = 16'h0000;
    int rx_cnt = 0;
    logic [7:0] payload_mem[0:MAX_PAYLOAD-1];

    sum_checked_packet_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .packet_type    (packet_type),
        .payload_length (payload_length),
        .record_number  (record_number),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 30)
            $display("%0t mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void expect_beat(status_t st, logic [7:0] ty, logic [LEN_W-1:0] len,
                                        logic [15:0] rec, logic [7:0] pb,
                                        logic [IDX_W-1:0] idx, logic fin);
        expected_beats.push_back('{st, ty, len, rec, pb, idx, fin});
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        int i;
        if (parse_ph != PH_HUNT)
            run_sum = run_sum + b;
        case (parse_ph)
            PH_HUNT:
                if (b == PREAMBLE)
                begin
                    parse_ph = PH_TYPE;
                    run_sum = PREAMBLE;
                end
            PH_TYPE:
            begin
                hold_type = b;
                if (b < type_limit)
                    parse_ph = PH_LEN;
                else
                begin
                    expect_beat(ST_BAD_TYPE, b, '0, '0, '0, '0, 1'b1);
                    parse_ph = PH_HUNT;
                end
            end
            PH_LEN:
                if (b <= MAX_PAYLOAD)
                begin
                    hold_len = b[LEN_W-1:0];
                    if (b != 0)
                        parse_ph = PH_RECH;
                    else
                    begin
                        hold_rec = '0;
                        parse_ph = PH_CHK;
                    end
                end
                else
                begin
                    expect_beat(ST_BAD_LEN, '0, '0, '0, '0, '0, 1'b1);
                    parse_ph = PH_HUNT;
                end
            PH_RECH:
            begin
                hold_rec = {b, 8'h00};
                parse_ph = PH_RECL;
            end
            PH_RECL:
            begin
                hold_rec[7:0] = b;
                rx_cnt = 0;
                parse_ph = PH_DATA;
            end
            PH_DATA:
            begin
                if (rx_cnt < MAX_PAYLOAD)
                    payload_mem[rx_cnt] = b;
                rx_cnt++;
                if (rx_cnt >= hold_len)
                    parse_ph = PH_CHK;
            end
            PH_CHK:
            begin
                if (run_sum != 8'h00)
                    expect_beat(ST_BAD_SUM, hold_type, hold_len, hold_rec, '0, '0, 1'b1);
                else if (hold_len == 0)
                    expect_beat(ST_GOOD, hold_type, '0, '0, '0, '0, 1'b1);
                else
                    for (i = 0; i < hold_len; i++)
                        expect_beat(ST_GOOD, hold_type, hold_len, hold_rec, payload_mem[i],
                                    IDX_W'(i), (i + 1 == hold_len));
                parse_ph = PH_HUNT;
            end
            default:
                parse_ph = PH_HUNT;
        endcase
        if (parse_ph == PH_HUNT)
            run_sum = 8'h00;
    endtask

    // driver: one byte per beat, fed from rx_stream
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            if (!in_valid || in_ready)
            begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_stream.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_beats.pop_front();
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d exp %0d", status, want.st));
                    if (packet_type !== want.ptype)
                        report_mismatch($sformatf("packet_type %0h exp %0h",
                                                  packet_type, want.ptype));
                    if (payload_length !== want.len)
                        report_mismatch($sformatf("payload_length %0d exp %0d",
                                                  payload_length, want.len));
                    if (record_number !== want.rec)
                        report_mismatch($sformatf("record_number %0h exp %0h",
                                                  record_number, want.rec));
                    if (payload_byte !== want.pbyte)
                        report_mismatch($sformatf("payload_byte %0h exp %0h",
                                                  payload_byte, want.pbyte));
                    if (byte_index !== want.idx)
                        report_mismatch($sformatf("byte_index %0d exp %0d",
                                                  byte_index, want.idx));
                    if (last !== want.fin)
                        report_mismatch($sformatf("last %0b exp %0b", last, want.fin));
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles == QUIET_LIMIT)
                begin
                    $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                    $display("[sum_checked_packet_deframer] ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic add_packet(input logic [7:0] ty, input int len, input logic [15:0] rec,
                              input int keep, input bit corrupt);
        logic [7:0] pk[$];
        logic [7:0] sum;
        logic [7:0] chk;
        pk.push_back(PREAMBLE);
        pk.push_back(ty);
        pk.push_back(len[7:0]);
        if (len != 0)
        begin
            pk.push_back(rec[15:8]);
            pk.push_back(rec[7:0]);
            repeat (len) pk.push_back(8'($urandom));
        end
        sum = 8'h00;
        foreach (pk[k]) sum += pk[k];
        chk = 8'h00 - sum;
        if (corrupt)
            chk += 8'($urandom_range(255, 1));
        pk.push_back(chk);
        while (pk.size() > keep)
            void'(pk.pop_back());
        foreach (pk[k]) rx_stream.push_back(pk[k]);
    endtask

    function automatic logic [7:0] good_type();
        if (type_limit == 0)
            return 8'($urandom);
        return 8'($urandom_range(int'(type_limit) - 1));
    endfunction

    task automatic add_random();
        int r;
        int len;
        r = $urandom_range(99);
        // mostly short payloads, some mid, some full size
        if ($urandom_range(99) < 70)
            len = $urandom_range(4);
        else if ($urandom_range(1))
            len = $urandom_range(31, 5);
        else
            len = MAX_PAYLOAD;
        if (r < 60)
            add_packet(good_type(), len, 16'($urandom), 1000, 1'b0);
        else if (r < 70)
            add_packet(good_type(), len, 16'($urandom), 1000, 1'b1);
        else if (r < 78)
            add_packet(8'($urandom_range(255, type_limit)), len, 16'($urandom), 2, 1'b0);
        else if (r < 85)
            add_packet(good_type(), $urandom_range(255, MAX_PAYLOAD + 1), 16'($urandom),
                       3, 1'b0);
        else if (r < 93)
            repeat ($urandom_range(3, 1)) rx_stream.push_back(8'($urandom));
        else
            add_packet(good_type(), len, 16'($urandom), $urandom_range(len + 4, 1), 1'b0);
    endtask

    // wait for all beats to finish, then push zeros until the parser is back to hunting
    task automatic settle();
        do
        begin
            do
                @(negedge clk);
            while (rx_stream.size() != 0 || in_valid || expected_beats.size() != 0);
            repeat (16) @(negedge clk);
            if (parse_ph != PH_HUNT)
                rx_stream.push_back(8'h00);
        end
        while (parse_ph != PH_HUNT);
    endtask

    task automatic run_phase(input logic [7:0] limit, input int s_pct, input int r_pct,
                             input int nbytes, input bit hold_off);
        int made;
        int prev;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        type_limit = limit;
        send_idle_pct = s_pct;
        stall_pct = r_pct;
        if (hold_off)
            fork
                begin
                    recv_hold <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    recv_hold <= 1'b0;
                end
            join_none
        made = 0;
        while (made < nbytes)
        begin
            prev = rx_stream.size();
            add_random();
            made += rx_stream.size() - prev;
        end
        settle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset type limit
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        add_packet(8'd4, 0, 16'h0000, 1000, 1'b0);
        // preamble as type: rejected, following byte must not restart
        rx_stream.push_back(PREAMBLE);
        rx_stream.push_back(PREAMBLE);
        rx_stream.push_back(8'h02);
        rx_stream.push_back(PREAMBLE);
        rx_stream.push_back(8'h01);
        rx_stream.push_back(8'd33);
        add_packet(8'd3, 2, 16'($urandom), 1000, 1'b1);
        // one-byte payload whose checksum byte is the preamble value
        rx_stream.push_back(PREAMBLE);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'h01);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hB5);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(PREAMBLE);
        rx_stream.push_back(8'h02);
        settle();

        run_phase(8'd255, 0, 0, 80, 1'b1);
        run_phase(8'd0, 75, 0, 50, 1'b0);
        run_phase(8'd1, 0, 75, 80, 1'b0);
        run_phase(8'($urandom_range(254, 2)), 32, 32, 90, 1'b0);
        run_phase(TYPE_LIMIT_RESET, 0, 0, 80, 1'b0);

        repeat (40) @(posedge clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));
        if (err_cnt == 0)
            $display("[sum_checked_packet_deframer] OK");
        else
            $display("[sum_checked_packet_deframer] ERROR");
        $finish;
    end

endmodule
